// ===== design/ssmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment multiplexed driver package
// Shared types, command codes, operation codes and the symbol table.
// ----------------------------------------------------------------------------
`default_nettype none

package ssmd_pkg;

  localparam int MaxDigitsDef = 8;

  localparam logic [2:0] CMD_WRITE_SYMBOL = 3'd0;
  localparam logic [2:0] CMD_WRITE_DEC    = 3'd1;
  localparam logic [2:0] CMD_WRITE_HEX    = 3'd2;
  localparam logic [2:0] CMD_CLEAR        = 3'd3;
  localparam logic [2:0] CMD_REFRESH      = 3'd4;

  localparam logic REG_DIGITS = 1'b0;
  localparam logic REG_ANODE  = 1'b1;

  localparam logic [3:0]  DIGITS_RESET  = 4'd4;
  localparam logic [31:0] DIV10_MAGIC   = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT   = 35;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SYMBOL,
    OP_DEC,
    OP_HEX,
    OP_CLEAR,
    OP_REFRESH
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  digit;
    logic [4:0]  symbol;
    logic [31:0] value;
  } cmd_t;

  function automatic logic [4:0] active_count(logic [3:0] digits, int unsigned maxd);
    logic [4:0] n;
    n = {1'b0, digits};
    if (n == 5'd0) begin
      n = 5'd1;
    end
    if (n > 5'(maxd)) begin
      n = 5'(maxd);
    end
    return n;
  endfunction

  function automatic logic [7:0] glyph_of(logic [4:0] sym);
    logic [7:0] g;
    case (sym)
      5'd0:    g = 8'h3F;
      5'd1:    g = 8'h06;
      5'd2:    g = 8'h5B;
      5'd3:    g = 8'h4F;
      5'd4:    g = 8'h66;
      5'd5:    g = 8'h6D;
      5'd6:    g = 8'h7D;
      5'd7:    g = 8'h07;
      5'd8:    g = 8'h7F;
      5'd9:    g = 8'h6F;
      5'd10:   g = 8'h5F;
      5'd11:   g = 8'h7C;
      5'd12:   g = 8'h58;
      5'd13:   g = 8'h5E;
      5'd14:   g = 8'h7B;
      5'd15:   g = 8'h71;
      5'd16:   g = 8'h77;
      5'd17:   g = 8'h39;
      5'd18:   g = 8'h79;
      5'd19:   g = 8'h76;
      5'd20:   g = 8'h1E;
      5'd21:   g = 8'h38;
      5'd22:   g = 8'h73;
      5'd23:   g = 8'h3E;
      5'd24:   g = 8'h80;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== design/ssmd_front.sv =====
// ----------------------------------------------------------------------------
// Seven-segment driver command front end
// Decodes incoming commands into operations and queues them for execution.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmd_front import ssmd_pkg::*; #(
  parameter int MAX_DIGITS = MaxDigitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [2:0]  in_digit_index,
  input  wire logic [4:0]  in_symbol_index,
  input  wire logic [31:0] in_value,
  input  wire logic [3:0]  digits_in_use,
  input  wire logic        pop,
  output logic             q_valid,
  output cmd_t             q_entry
);

  cmd_t       queue_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic [4:0] n_active;
  cmd_t       entry;

  assign n_active = active_count(digits_in_use, MAX_DIGITS);
  assign busy     = (count_r == 2'd2);
  assign push     = start && !busy;
  assign q_valid  = (count_r != 2'd0);
  assign q_entry  = queue_r[rd_ptr_r];

  always_comb begin
    entry.digit  = in_digit_index;
    entry.symbol = in_symbol_index;
    entry.value  = in_value;
    unique case (in_command)
      CMD_WRITE_SYMBOL: begin
        entry.op = ({2'b00, in_digit_index} < n_active) ? OP_SYMBOL : OP_NOP;
      end
      CMD_WRITE_DEC: begin
        entry.op = OP_DEC;
      end
      CMD_WRITE_HEX: begin
        entry.op = OP_HEX;
      end
      CMD_CLEAR: begin
        entry.op = OP_CLEAR;
      end
      CMD_REFRESH: begin
        entry.op = OP_REFRESH;
      end
      default: begin
        entry.op = OP_NOP;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("push lost");
`endif

endmodule

`default_nettype wire

// ===== design/ssmd_back.sv =====
// ----------------------------------------------------------------------------
// Seven-segment driver execution back end
// Holds the symbol store and drive state, executes queued operations and
// issues one result per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmd_back import ssmd_pkg::*; #(
  parameter int MAX_DIGITS = MaxDigitsDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire cmd_t       q_entry,
  output logic            pop,
  input  wire logic [3:0] digits_in_use,
  input  wire logic       common_anode,
  output logic            out_valid,
  output logic [7:0]      out_segment_lines,
  output logic [7:0]      out_digit_lines,
  output logic [2:0]      out_scan_digit
);

  localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FILL = 1'b1;

  logic [4:0]    store_r [MAX_DIGITS];
  logic          st_r, st_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0]   val_r, val_nxt;
  logic          hex_r, hex_nxt;
  logic [7:0]    seg_r, seg_nxt;
  logic [7:0]    dig_r, dig_nxt;
  logic          valid_r, valid_nxt;

  logic [4:0]    n_active;
  logic          last;
  logic [63:0]   prod;
  logic [31:0]   quot;
  logic [31:0]   rem;
  logic [4:0]    fill_sym;
  logic [4:0]    next5;
  logic [PW-1:0] next_idx;
  logic [15:0]   pos_ext;

  assign n_active = active_count(digits_in_use, MAX_DIGITS);
  assign pop      = q_valid && (st_r == S_IDLE);
  assign last     = (5'(cnt_r) == n_active - 5'd1);

  assign prod     = 64'(val_r) * 64'(DIV10_MAGIC);
  assign quot     = 32'(prod[63:DIV10_SHIFT]);
  assign rem      = val_r - ((quot << 3) + (quot << 1));
  assign fill_sym = hex_r ? {1'b0, val_r[3:0]} : {1'b0, rem[3:0]};

  always_comb begin
    next5 = 5'(pos_r) + 5'd1;
    if (next5 >= n_active) begin
      next5 = 5'd0;
    end
    next_idx = PW'(next5);
  end

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    hex_nxt   = hex_r;
    seg_nxt   = seg_r;
    dig_nxt   = dig_r;
    valid_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (pop) begin
          unique case (q_entry.op) inside
            OP_DEC, OP_HEX: begin
              st_nxt  = S_FILL;
              cnt_nxt = '0;
              val_nxt = q_entry.value;
              hex_nxt = (q_entry.op == OP_HEX);
            end
            OP_REFRESH: begin
              pos_nxt   = next_idx;
              seg_nxt   = glyph_of(store_r[next_idx]);
              for (int k = 0; k < 8; k++) begin
                dig_nxt[k] = (next5 == 5'(k));
              end
              valid_nxt = 1'b1;
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        val_nxt = hex_r ? (val_r >> 4) : quot;
        if (last) begin
          st_nxt    = S_IDLE;
          valid_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + PW'(1);
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
      seg_r   <= 8'h00;
      dig_r   <= 8'h00;
      valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      seg_r   <= seg_nxt;
      dig_r   <= dig_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    hex_r <= hex_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
        store_r[k] <= 5'd0;
      end
    end else if (st_r == S_FILL) begin
      store_r[cnt_r] <= fill_sym;
    end else if (pop && q_entry.op == OP_SYMBOL) begin
      store_r[PW'(q_entry.digit)] <= q_entry.symbol;
    end else if (pop && q_entry.op == OP_CLEAR) begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
        store_r[k] <= 5'd0;
      end
    end
  end

  assign pos_ext           = 16'(pos_r);
  assign out_valid         = valid_r;
  assign out_segment_lines = seg_r ^ {8{common_anode}};
  assign out_digit_lines   = dig_r ^ {8{common_anode}};
  assign out_scan_digit    = pos_ext[2:0];

`ifndef SYNTHESIS
  a_digit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(dig_r))
    else $error("more than one digit enabled");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    5'(pos_r) < 5'(MAX_DIGITS))
    else $error("scan position out of range");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FILL) |-> 5'(cnt_r) < n_active)
    else $error("fill counter beyond digits in use");
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FILL && last) |=> (valid_r && st_r == S_IDLE))
    else $error("fill did not complete with a result");
`endif

endmodule

`default_nettype wire

// ===== design/seven_segment_mux_driver_unit.sv =====
// ----------------------------------------------------------------------------
// Seven-segment multiplexed driver
// Command-driven controller for a multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. The
// commands write one symbol, fill the digits in use from a decimal or hex
// value, clear the symbol store, or advance the refresh scan. Every command
// produces exactly one result transaction: out_valid is high for one cycle
// with the segment pins, digit pins and scanned digit after the command.
// Single-step commands pass through the queue and the registered result
// and can be accepted every cycle while the back end is not filling digits.
// Decimal and hex writes walk the digits one per cycle, decimal through a
// divide-by-ten unit and hex by four-bit shifts; the back end takes no new
// command until the last digit in use is written, and then gives the result.
// A two-entry command queue separates decoding from execution; busy rises
// only while that queue is full. Results cannot be stalled.
// Reset clears the store, the scan position and both drive patterns, and
// sets the digit count register to four with common-cathode levels.
// The configuration registers are at byte addresses 0 and 4 of the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_mux_driver_unit import ssmd_pkg::*; #(
  parameter int MAX_DIGITS = MaxDigitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [2:0]  in_digit_index,
  input  wire logic [4:0]  in_symbol_index,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  output logic [7:0]       out_segment_lines,
  output logic [7:0]       out_digit_lines,
  output logic [2:0]       out_scan_digit,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0] digits_r;
  logic       anode_r;
  logic       cfg_write;
  logic       pop;
  logic       q_valid;
  cmd_t       q_entry;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_ANODE) ? {31'd0, anode_r} : {28'd0, digits_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= DIGITS_RESET;
      anode_r  <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == REG_DIGITS) begin
        digits_r <= pwdata[3:0];
      end else begin
        anode_r <= pwdata[0];
      end
    end
  end

  ssmd_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_digit_index (in_digit_index),
    .in_symbol_index(in_symbol_index),
    .in_value       (in_value),
    .digits_in_use  (digits_r),
    .pop            (pop),
    .q_valid        (q_valid),
    .q_entry        (q_entry)
  );

  ssmd_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .pop              (pop),
    .digits_in_use    (digits_r),
    .common_anode     (anode_r),
    .out_valid        (out_valid),
    .out_segment_lines(out_segment_lines),
    .out_digit_lines  (out_digit_lines),
    .out_scan_digit   (out_scan_digit)
  );

endmodule

`default_nettype wire
